// ----- src/lyp_pkg.sv -----
// shared constants, types and functions of the look direction to yaw and pitch unit
package lyp_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int FRAC_BITS_DEF     = 16;
    localparam int ATAN_LEN          = 24;

    localparam int D_W    = 33;   // exact direction component
    localparam int NORM_W = 31;   // normalized component, magnitude below 2^30
    localparam int SQ_W   = 62;   // radicand of the horizontal length
    localparam int SQRT_CELLS = SQ_W / 2;
    localparam int CX_W   = 36;   // cordic x and y
    localparam int CZ_W   = 35;   // cordic angle, radians scaled by 2^30

    localparam logic [15:0] MIN_DIST_RST = 16'd66;
    localparam logic signed [CZ_W-1:0] HALF_PI_Q30 = CZ_W'(64'sd1686629713);
    localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;

    typedef struct packed {
        logic                   coin;
        logic                   vert;
        logic                   vneg;
        logic [31:0]            look_x;
        logic [31:0]            look_y;
        logic [31:0]            look_z;
        logic signed [31:0]     pitch_y;
        logic signed [CX_W-1:0] yaw_x;
        logic signed [CX_W-1:0] yaw_y;
        logic signed [CZ_W-1:0] yaw_z;
    } side_t;

    function automatic logic [CZ_W-1:0] lyp_atan(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'h3243F6A8;
            1:       v = 32'h1DAC6705;
            2:       v = 32'h0FADBAFC;
            3:       v = 32'h07F56EA6;
            4:       v = 32'h03FEAB76;
            5:       v = 32'h01FFD55B;
            6:       v = 32'h00FFFAAA;
            7:       v = 32'h007FFF55;
            8:       v = 32'h003FFFEA;
            9:       v = 32'h001FFFFD;
            10:      v = 32'h000FFFFF;
            11:      v = 32'h0007FFFF;
            12:      v = 32'h0003FFFF;
            13:      v = 32'h0001FFFF;
            14:      v = 32'h0000FFFF;
            15:      v = 32'h00007FFF;
            16:      v = 32'h00003FFF;
            17:      v = 32'h00001FFF;
            18:      v = 32'h00000FFF;
            19:      v = 32'h000007FF;
            20:      v = 32'h000003FF;
            21:      v = 32'h000001FF;
            22:      v = 32'h000000FF;
            23:      v = 32'h0000007F;
            default: v = 32'h0;
        endcase
        return {{(CZ_W-32){1'b0}}, v};
    endfunction

    function automatic logic [31:0] lyp_abs33(input logic signed [D_W-1:0] d);
        logic signed [D_W-1:0] m;
        m = d[D_W-1] ? -d : d;
        return m[31:0];
    endfunction

    // round half up to Q3.13 and saturate
    function automatic logic signed [15:0] lyp_round(input logic signed [CZ_W-1:0] z);
        logic signed [CZ_W:0]    t;
        logic signed [CZ_W-17:0] q;
        t = {z[CZ_W-1], z} + (CZ_W+1)'(65536);
        q = (CZ_W-16)'(t >>> 17);
        if (q > (CZ_W-16)'(32767)) begin
            return 16'sh7FFF;
        end else if (q < -(CZ_W-16)'(32768)) begin
            return 16'sh8000;
        end
        return q[15:0];
    endfunction

endpackage

// ----- src/lyp_norm.sv -----
// block floating point scaling of a short vector so its largest magnitude is in [2^29, 2^30)
module lyp_norm #(
    parameter int N = 3
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [lyp_pkg::D_W-1:0]    d_in  [N],
    output logic signed [lyp_pkg::NORM_W-1:0] v_out [N]
);
    import lyp_pkg::*;

    logic [31:0]              mag_or;
    logic [4:0]               msb;
    logic signed [D_W-1:0]    d_a_reg [N];
    logic [4:0]               msb_a_reg;
    logic signed [NORM_W-1:0] v_b_reg [N];
    logic signed [NORM_W-1:0] v_c_reg [N];
    logic                     wrap_b;

    // msb of the largest magnitude equals the msb of the or of all magnitudes
    always_comb begin
        mag_or = '0;
        for (int i = 0; i < N; i++) begin
            mag_or = mag_or | lyp_abs33(d_in[i]);
        end
        msb = '0;
        for (int b = 0; b < 32; b++) begin
            if (mag_or[b]) begin
                msb = 5'(b);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_a_reg   <= d_in;
            msb_a_reg <= msb;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < N; i++) begin
                if (msb_a_reg > 5'd29) begin
                    v_b_reg[i] <= NORM_W'(d_a_reg[i] >>> (msb_a_reg - 5'd29));
                end else begin
                    v_b_reg[i] <= NORM_W'(d_a_reg[i] <<< (5'd29 - msb_a_reg));
                end
            end
        end
    end

    // floor shift of a negative value can land exactly on -2^30: one more step
    always_comb begin
        wrap_b = 1'b0;
        for (int i = 0; i < N; i++) begin
            if (v_b_reg[i] == {1'b1, {(NORM_W-1){1'b0}}}) begin
                wrap_b = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < N; i++) begin
                v_c_reg[i] <= wrap_b ? (v_b_reg[i] >>> 1) : v_b_reg[i];
            end
        end
    end

    assign v_out = v_c_reg;

endmodule

// ----- src/lyp_sqrt_cell.sv -----
// one result bit of the pipelined integer square root
module lyp_sqrt_cell #(
    parameter int K = 0
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [lyp_pkg::SQ_W-1:0]  n_in,
    input  logic [lyp_pkg::SQ_W-1:0]  r_in,
    output logic [lyp_pkg::SQ_W-1:0]  n_out,
    output logic [lyp_pkg::SQ_W-1:0]  r_out
);
    import lyp_pkg::*;

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * K);

    logic [SQ_W-1:0] trial;
    logic [SQ_W-1:0] n_reg;
    logic [SQ_W-1:0] r_reg;

    assign trial = r_in + BIT;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (n_in >= trial) begin
                n_reg <= n_in - trial;
                r_reg <= (r_in >> 1) + BIT;
            end else begin
                n_reg <= n_in;
                r_reg <= r_in >> 1;
            end
        end
    end

    assign n_out = n_reg;
    assign r_out = r_reg;

endmodule

// ----- src/lyp_cordic_cell.sv -----
// one vectoring cordic micro-rotation
module lyp_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic                             aclk,
    input  logic                             en,
    input  logic signed [lyp_pkg::CX_W-1:0]  x_in,
    input  logic signed [lyp_pkg::CX_W-1:0]  y_in,
    input  logic signed [lyp_pkg::CZ_W-1:0]  z_in,
    output logic signed [lyp_pkg::CX_W-1:0]  x_out,
    output logic signed [lyp_pkg::CX_W-1:0]  y_out,
    output logic signed [lyp_pkg::CZ_W-1:0]  z_out
);
    import lyp_pkg::*;

    localparam logic signed [CZ_W-1:0] ANG = lyp_atan(IDX);

    logic signed [CX_W-1:0] x_reg;
    logic signed [CX_W-1:0] y_reg;
    logic signed [CZ_W-1:0] z_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (y_in > 0) begin
                x_reg <= x_in + (y_in >>> IDX);
                y_reg <= y_in - (x_in >>> IDX);
                z_reg <= z_in + ANG;
            end else begin
                x_reg <= x_in - (y_in >>> IDX);
                y_reg <= y_in + (x_in >>> IDX);
                z_reg <= z_in - ANG;
            end
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// ----- src/look_direction_to_yaw_pitch_unit.sv -----
// top level: camera look direction to pitch and yaw angles
//
// Input channel s_*: camera position and look-at point, signed Q16.16.
// Result channel m_*: pitch and yaw as signed Q3.13 radians, the coincident
// flag and the look-at point, moved to position + (1,0,0) when coincident.
// Config channel cfg_*: min_distance, taken in any cycle (cfg_ready is high).
// The pipeline holds six setup stages (difference, coincidence test and block
// scaling, squares), 31 square root cells, the cordic cells and the output
// register. One word is accepted every cycle while the chain advances; the
// cell chains set the latency, not rate. All stages advance together; when
// the receiver holds m_ready low with a word waiting, the whole chain holds
// and s_ready falls in the same cycle.
// Synchronous reset empties the pipeline and sets min_distance to 66.
module look_direction_to_yaw_pitch_unit #(
    parameter int CORDIC_STAGES = lyp_pkg::CORDIC_STAGES_DEF,
    parameter int FRAC_BITS     = lyp_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic signed [31:0] s_look_x,
    input  logic signed [31:0] s_look_y,
    input  logic signed [31:0] s_look_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_pitch_angle,
    output logic signed [15:0] m_yaw_angle,
    output logic               m_coincident,
    output logic signed [31:0] m_new_look_x,
    output logic signed [31:0] m_new_look_y,
    output logic signed [31:0] m_new_look_z
);
    import lyp_pkg::*;

    localparam int PRE      = 6;
    localparam int LINE     = SQRT_CELLS + CORDIC_STAGES;
    localparam int PIPE_LEN = PRE + LINE;

    logic en;
    logic [31:0] md2_reg;
    logic [PIPE_LEN-1:0] vld_reg;
    logic [PIPE_LEN-1:0] vld_next;
    logic m_valid_reg;

    // stage 1
    logic signed [D_W-1:0] dx1_reg, dy1_reg, dz1_reg;
    logic [31:0] px1_reg, py1_reg, pz1_reg, lx1_reg, ly1_reg, lz1_reg;
    // stage 2
    logic        small2_reg, vert2_reg, vneg2_reg;
    logic [31:0] sqx2_reg, sqy2_reg, sqz2_reg;
    logic [31:0] px2_reg, py2_reg, pz2_reg, lx2_reg, ly2_reg, lz2_reg;
    logic signed [2*17-1:0] sqx2, sqy2, sqz2;
    // stage 3
    logic        coin3_reg, vert3_reg, vneg3_reg;
    logic [31:0] nx3_reg, ny3_reg, nz3_reg;
    logic [33:0] len2;
    logic        coin3;
    // stage 4
    logic        coin4_reg, vert4_reg, vneg4_reg;
    logic [31:0] nx4_reg, ny4_reg, nz4_reg;
    // stage 5 and 6
    side_t       side5_reg;
    side_t       side5_next;
    logic [59:0] sqx5_reg, sqz5_reg;
    logic signed [61:0] vxe, vze;
    logic [SQ_W-1:0] n6_reg;

    logic signed [D_W-1:0]    n3_in [3];
    logic signed [NORM_W-1:0] n3_out [3];
    logic signed [D_W-1:0]    n2_in [2];
    logic signed [NORM_W-1:0] n2_out [2];

    side_t           side_reg [LINE+1];
    logic [SQ_W-1:0] sn_w [SQRT_CELLS+1];
    logic [SQ_W-1:0] sr_w [SQRT_CELLS+1];
    logic signed [CX_W-1:0] px_w [CORDIC_STAGES+1];
    logic signed [CX_W-1:0] py_w [CORDIC_STAGES+1];
    logic signed [CZ_W-1:0] pz_w [CORDIC_STAGES+1];
    logic signed [CX_W-1:0] yx_w [CORDIC_STAGES+1];
    logic signed [CX_W-1:0] yy_w [CORDIC_STAGES+1];
    logic signed [CZ_W-1:0] yz_w [CORDIC_STAGES+1];

    logic signed [15:0] pitch_reg, yaw_reg;
    logic               coin_out_reg;
    logic [31:0]        olx_reg, oly_reg, olz_reg;

    assign en        = !m_valid_reg || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            md2_reg <= 32'(MIN_DIST_RST) * 32'(MIN_DIST_RST);
        end else if (cfg_valid) begin
            md2_reg <= 32'(cfg_data) * 32'(cfg_data);
        end
    end

    assign vld_next = {vld_reg[PIPE_LEN-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= vld_next;
            m_valid_reg <= vld_reg[PIPE_LEN-1];
        end
    end

    // stage 1: exact direction
    always_ff @(posedge aclk) begin
        if (en) begin
            dx1_reg <= {s_look_x[31], s_look_x} - {s_pos_x[31], s_pos_x};
            dy1_reg <= {s_look_y[31], s_look_y} - {s_pos_y[31], s_pos_y};
            dz1_reg <= {s_look_z[31], s_look_z} - {s_pos_z[31], s_pos_z};
            px1_reg <= s_pos_x;
            py1_reg <= s_pos_y;
            pz1_reg <= s_pos_z;
            lx1_reg <= s_look_x;
            ly1_reg <= s_look_y;
            lz1_reg <= s_look_z;
        end
    end

    always_comb begin
        n3_in[0] = dx1_reg;
        n3_in[1] = dy1_reg;
        n3_in[2] = dz1_reg;
        n2_in[0] = dx1_reg;
        n2_in[1] = dz1_reg;
    end

    lyp_norm #(.N(3)) u_norm_pitch (
        .aclk  (aclk),
        .en    (en),
        .d_in  (n3_in),
        .v_out (n3_out)
    );

    lyp_norm #(.N(2)) u_norm_yaw (
        .aclk  (aclk),
        .en    (en),
        .d_in  (n2_in),
        .v_out (n2_out)
    );

    // stage 2: short-range squares for the coincidence test
    assign sqx2 = $signed(dx1_reg[16:0]) * $signed(dx1_reg[16:0]);
    assign sqy2 = $signed(dy1_reg[16:0]) * $signed(dy1_reg[16:0]);
    assign sqz2 = $signed(dz1_reg[16:0]) * $signed(dz1_reg[16:0]);

    always_ff @(posedge aclk) begin
        if (en) begin
            small2_reg <= (lyp_abs33(dx1_reg) < 32'd65536) && (lyp_abs33(dy1_reg) < 32'd65536)
                       && (lyp_abs33(dz1_reg) < 32'd65536);
            vert2_reg  <= (dx1_reg == '0) && (dz1_reg == '0);
            vneg2_reg  <= dy1_reg[D_W-1];
            sqx2_reg   <= sqx2[31:0];
            sqy2_reg   <= sqy2[31:0];
            sqz2_reg   <= sqz2[31:0];
            px2_reg    <= px1_reg;
            py2_reg    <= py1_reg;
            pz2_reg    <= pz1_reg;
            lx2_reg    <= lx1_reg;
            ly2_reg    <= ly1_reg;
            lz2_reg    <= lz1_reg;
        end
    end

    // stage 3: coincidence decision and corrected look-at
    assign len2  = 34'(sqx2_reg) + 34'(sqy2_reg) + 34'(sqz2_reg);
    assign coin3 = small2_reg && (len2 < 34'(md2_reg));

    always_ff @(posedge aclk) begin
        if (en) begin
            coin3_reg <= coin3;
            vert3_reg <= vert2_reg;
            vneg3_reg <= vneg2_reg;
            nx3_reg   <= coin3 ? px2_reg + (32'(1) << FRAC_BITS) : lx2_reg;
            ny3_reg   <= coin3 ? py2_reg : ly2_reg;
            nz3_reg   <= coin3 ? pz2_reg : lz2_reg;
        end
    end

    // stage 4: lines up with the scaled vectors
    always_ff @(posedge aclk) begin
        if (en) begin
            coin4_reg <= coin3_reg;
            vert4_reg <= vert3_reg;
            vneg4_reg <= vneg3_reg;
            nx4_reg   <= nx3_reg;
            ny4_reg   <= ny3_reg;
            nz4_reg   <= nz3_reg;
        end
    end

    // stage 5: horizontal squares, yaw quadrant fold
    assign vxe = 62'(n3_out[0]);
    assign vze = 62'(n3_out[2]);

    always_comb begin
        side5_next.coin    = coin4_reg;
        side5_next.vert    = vert4_reg;
        side5_next.vneg    = vneg4_reg;
        side5_next.look_x  = nx4_reg;
        side5_next.look_y  = ny4_reg;
        side5_next.look_z  = nz4_reg;
        side5_next.pitch_y = -32'(n3_out[1]);
        if (n2_out[1] < 0) begin
            if (n2_out[0] >= 0) begin
                side5_next.yaw_x = CX_W'(n2_out[1]);
                side5_next.yaw_y = -CX_W'(n2_out[0]);
                side5_next.yaw_z = -HALF_PI_Q30;
            end else begin
                side5_next.yaw_x = -CX_W'(n2_out[1]);
                side5_next.yaw_y = CX_W'(n2_out[0]);
                side5_next.yaw_z = HALF_PI_Q30;
            end
            // atan2(x, z): z is the cordic x axis, x the y axis
            side5_next.yaw_x = -side5_next.yaw_x;
            side5_next.yaw_y = -side5_next.yaw_y;
            side5_next.yaw_z = -side5_next.yaw_z;
            if (n2_out[0] >= 0) begin
                side5_next.yaw_x = CX_W'(n2_out[0]);
                side5_next.yaw_y = -CX_W'(n2_out[1]);
                side5_next.yaw_z = HALF_PI_Q30;
            end else begin
                side5_next.yaw_x = -CX_W'(n2_out[0]);
                side5_next.yaw_y = CX_W'(n2_out[1]);
                side5_next.yaw_z = -HALF_PI_Q30;
            end
        end else begin
            side5_next.yaw_x = CX_W'(n2_out[1]);
            side5_next.yaw_y = CX_W'(n2_out[0]);
            side5_next.yaw_z = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side5_reg <= side5_next;
            sqx5_reg  <= 60'(vxe * vxe);
            sqz5_reg  <= 60'(vze * vze);
        end
    end

    // stage 6: radicand
    always_ff @(posedge aclk) begin
        if (en) begin
            n6_reg      <= SQ_W'(sqx5_reg) + SQ_W'(sqz5_reg);
            side_reg[0] <= side5_reg;
        end
    end

    genvar k;
    generate
        for (k = 1; k <= LINE; k++) begin : g_side
            always_ff @(posedge aclk) begin
                if (en) begin
                    side_reg[k] <= side_reg[k-1];
                end
            end
        end
    endgenerate

    assign sn_w[0] = n6_reg;
    assign sr_w[0] = '0;

    generate
        for (k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
            lyp_sqrt_cell #(.K(SQRT_CELLS - 1 - k)) u_cell (
                .aclk  (aclk),
                .en    (en),
                .n_in  (sn_w[k]),
                .r_in  (sr_w[k]),
                .n_out (sn_w[k+1]),
                .r_out (sr_w[k+1])
            );
        end
    endgenerate

    assign px_w[0] = CX_W'(sr_w[SQRT_CELLS][30:0]);
    assign py_w[0] = CX_W'(side_reg[SQRT_CELLS].pitch_y);
    assign pz_w[0] = '0;
    assign yx_w[0] = side_reg[SQRT_CELLS].yaw_x;
    assign yy_w[0] = side_reg[SQRT_CELLS].yaw_y;
    assign yz_w[0] = side_reg[SQRT_CELLS].yaw_z;

    generate
        for (k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
            lyp_cordic_cell #(.IDX(k)) u_pitch (
                .aclk  (aclk),
                .en    (en),
                .x_in  (px_w[k]),
                .y_in  (py_w[k]),
                .z_in  (pz_w[k]),
                .x_out (px_w[k+1]),
                .y_out (py_w[k+1]),
                .z_out (pz_w[k+1])
            );
            lyp_cordic_cell #(.IDX(k)) u_yaw (
                .aclk  (aclk),
                .en    (en),
                .x_in  (yx_w[k]),
                .y_in  (yy_w[k]),
                .z_in  (yz_w[k]),
                .x_out (yx_w[k+1]),
                .y_out (yy_w[k+1]),
                .z_out (yz_w[k+1])
            );
        end
    endgenerate

    // output word
    always_ff @(posedge aclk) begin
        if (en) begin
            coin_out_reg <= side_reg[LINE].coin;
            olx_reg      <= side_reg[LINE].look_x;
            oly_reg      <= side_reg[LINE].look_y;
            olz_reg      <= side_reg[LINE].look_z;
            if (side_reg[LINE].coin) begin
                pitch_reg <= '0;
                yaw_reg   <= '0;
            end else if (side_reg[LINE].vert) begin
                pitch_reg <= side_reg[LINE].vneg ? HALF_PI_Q13 : -HALF_PI_Q13;
                yaw_reg   <= '0;
            end else begin
                pitch_reg <= lyp_round(pz_w[CORDIC_STAGES]);
                yaw_reg   <= lyp_round(yz_w[CORDIC_STAGES]);
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pitch_angle = pitch_reg;
    assign m_yaw_angle   = yaw_reg;
    assign m_coincident  = coin_out_reg;
    assign m_new_look_x  = olx_reg;
    assign m_new_look_y  = oly_reg;
    assign m_new_look_z  = olz_reg;

    a_coin_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_coincident |-> m_pitch_angle == '0 && m_yaw_angle == '0)
        else $error("coincident word with nonzero angle");

    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_pitch_angle <= 16'sd12996 && m_pitch_angle >= -16'sd12996)
        else $error("pitch beyond a quarter turn");

endmodule
